[hw/rtl/pdss_pkg.sv]
package pdss_pkg;

   localparam int BUF_DEPTH_DEFAULT    = 256;
   localparam int MAX_SEGMENTS_DEFAULT = 128;
   localparam int QUEUE_DEPTH          = 4;

   localparam logic [7:0] SLASH_BYTE = 8'h2F;
   localparam logic [7:0] DOT_BYTE   = 8'h2E;

   localparam logic MODE_PUSH = 1'b0;
   localparam logic MODE_READ = 1'b1;

   typedef struct packed {
      logic       mode;
      logic [7:0] data_byte;
      logic       end_of_path;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_valid;
      logic       out_last;
      logic       overflow;
   } rsp_type;

   // classified item handed from the front to the back
   typedef struct packed {
      req_type req;
      logic    is_slash;
      logic    is_dot;
   } token_type;

endpackage

[hw/rtl/pdss_ram.sv]
module pdss_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = pdss_pkg::BUF_DEPTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/pdss_fifo.sv]
module pdss_fifo #(
   parameter type item_type = logic,
   parameter int  DEPTH     = pdss_pkg::QUEUE_DEPTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  item_type                   push_item,
   output logic                       full,
   input  logic                       pop,
   output item_type                   pop_item,
   output logic                       empty,
   output logic [$clog2(DEPTH+1)-1:0] count
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   item_type           store_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign count   = count_ff;
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign pop_item = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

[hw/rtl/pdss_front.sv]
module pdss_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   input  pdss_pkg::req_type     req_data,
   output logic                  req_full,
   input  logic                  tok_pop,
   output pdss_pkg::token_type   tok,
   output logic                  tok_empty
);

   pdss_pkg::token_type tok_in;

   // classify the byte once so the back only tests flags
   always_comb begin
      tok_in.req      = req_data;
      tok_in.is_slash = (req_data.data_byte == pdss_pkg::SLASH_BYTE);
      tok_in.is_dot   = (req_data.data_byte == pdss_pkg::DOT_BYTE);
   end

   pdss_fifo #(
      .item_type (pdss_pkg::token_type),
      .DEPTH     (pdss_pkg::QUEUE_DEPTH)
   ) u_tok_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_item (tok_in),
      .full      (req_full),
      .pop       (tok_pop),
      .pop_item  (tok),
      .empty     (tok_empty),
      .count     ()
   );

endmodule

[hw/rtl/pdss_back.sv]
module pdss_back #(
   parameter int BUF_DEPTH    = pdss_pkg::BUF_DEPTH_DEFAULT,
   parameter int MAX_SEGMENTS = pdss_pkg::MAX_SEGMENTS_DEFAULT
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       tok_empty,
   input  pdss_pkg::token_type                        tok,
   output logic                                       tok_pop,
   input  logic [$clog2(pdss_pkg::QUEUE_DEPTH+1)-1:0] out_count,
   output logic                                       rsp_push,
   output pdss_pkg::rsp_type                          rsp_item
);

   localparam int AW     = $clog2(BUF_DEPTH);
   localparam int LEN_W  = $clog2(BUF_DEPTH + 1);
   localparam int SAW    = $clog2(MAX_SEGMENTS);
   localparam int DEP_W  = $clog2(MAX_SEGMENTS + 1);
   localparam int OCNT_W = $clog2(pdss_pkg::QUEUE_DEPTH + 1);

   // path state
   logic [LEN_W-1:0] committed_ff, committed_in;
   logic [LEN_W-1:0] seglen_ff, seglen_in;
   logic             alldots_ff, alldots_in;
   logic [DEP_W-1:0] depth_ff, depth_in;
   logic [AW-1:0]    top_ff, top_in;
   logic [LEN_W-1:0] rdptr_ff, rdptr_in;
   logic             finished_ff, finished_in;
   logic             overflow_ff, overflow_in;
   logic             pend_ff, pend_in;
   logic [AW-1:0]    pend_addr_ff, pend_addr_in;

   // result stage
   logic              s2_valid_ff, s2_valid_in;
   logic              s2_ram_ff, s2_ram_in;
   pdss_pkg::rsp_type s2_item_ff, s2_item_in;

   // memories
   logic             buf_we;
   logic [AW-1:0]    buf_waddr, buf_raddr;
   logic [7:0]       buf_wdata, buf_rdata;
   logic             stk_we;
   logic [SAW-1:0]   stk_waddr, stk_raddr;
   logic [AW-1:0]    stk_rdata;
   logic [DEP_W-1:0] stk_rsel;

   // working values
   logic             issue;
   logic [LEN_W:0]   pos;
   logic [LEN_W-1:0] cl_len;
   logic             cl_dots;
   logic             byte_stored;
   logic [LEN_W-1:0] rd_next;

   assign issue = !tok_empty && !pend_ff &&
                  ((OCNT_W + 1)'(out_count) + (OCNT_W + 1)'(s2_valid_ff)
                   < (OCNT_W + 1)'(pdss_pkg::QUEUE_DEPTH));
   assign tok_pop = issue;

   assign rd_next   = rdptr_ff + 1'b1;
   assign buf_raddr = (rdptr_ff >= LEN_W'(BUF_DEPTH)) ? AW'(BUF_DEPTH - 1) : rdptr_ff[AW-1:0];
   assign stk_waddr = depth_ff[SAW-1:0];
   // prefetch the entry under the top for the next pop
   assign stk_rsel  = depth_in - DEP_W'(2);
   assign stk_raddr = stk_rsel[SAW-1:0];

   always_comb begin
      committed_in = committed_ff;
      seglen_in    = seglen_ff;
      alldots_in   = alldots_ff;
      depth_in     = depth_ff;
      top_in       = top_ff;
      rdptr_in     = rdptr_ff;
      finished_in  = finished_ff;
      overflow_in  = overflow_ff;
      pend_in      = 1'b0;
      pend_addr_in = pend_addr_ff;
      s2_valid_in  = 1'b0;
      s2_ram_in    = 1'b0;
      s2_item_in   = '0;
      buf_we       = 1'b0;
      buf_waddr    = committed_ff[AW-1:0];
      buf_wdata    = pdss_pkg::SLASH_BYTE;
      stk_we       = 1'b0;
      pos          = '0;
      cl_len       = seglen_ff;
      cl_dots      = alldots_ff;
      byte_stored  = 1'b0;

      if (pend_ff) begin
         // second write of an end byte: the '/' of the kept segment
         buf_we    = 1'b1;
         buf_waddr = pend_addr_ff;
      end else if (issue) begin
         s2_valid_in = 1'b1;
         if (tok.req.mode == pdss_pkg::MODE_PUSH) begin
            if (!finished_ff) begin
               if (!tok.is_slash) begin
                  pos = (LEN_W + 1)'(committed_ff) + (LEN_W + 1)'(1)
                        + (LEN_W + 1)'(seglen_ff);
                  if (pos < (LEN_W + 1)'(BUF_DEPTH)) begin
                     buf_we      = 1'b1;
                     buf_waddr   = pos[AW-1:0];
                     buf_wdata   = tok.req.data_byte;
                     cl_len      = seglen_ff + 1'b1;
                     cl_dots     = alldots_ff && tok.is_dot;
                     byte_stored = 1'b1;
                  end else begin
                     overflow_in = 1'b1;
                     cl_dots     = 1'b0;
                  end
               end
               seglen_in  = cl_len;
               alldots_in = cl_dots;
               if (tok.is_slash || tok.req.end_of_path) begin
                  seglen_in  = '0;
                  alldots_in = 1'b1;
                  if (cl_len == '0) begin
                     // empty segment: drop
                  end else if (cl_dots && cl_len == LEN_W'(1)) begin
                     // "." : drop
                  end else if (cl_dots && cl_len == LEN_W'(2)) begin
                     if (depth_ff != '0) begin
                        depth_in     = depth_ff - 1'b1;
                        committed_in = LEN_W'(top_ff);
                        top_in       = stk_rdata;
                     end
                  end else if (depth_ff == DEP_W'(MAX_SEGMENTS)) begin
                     overflow_in = 1'b1;
                  end else begin
                     stk_we       = 1'b1;
                     top_in       = committed_ff[AW-1:0];
                     depth_in     = depth_ff + 1'b1;
                     committed_in = committed_ff + LEN_W'(1) + cl_len;
                     if (byte_stored) begin
                        pend_in      = 1'b1;
                        pend_addr_in = committed_ff[AW-1:0];
                     end else begin
                        buf_we    = 1'b1;
                        buf_waddr = committed_ff[AW-1:0];
                     end
                  end
               end
               if (tok.req.end_of_path) begin
                  finished_in = 1'b1;
                  rdptr_in    = '0;
               end
            end
         end else if (finished_ff) begin
            s2_item_in.out_valid = 1'b1;
            if (committed_ff == '0) begin
               s2_item_in.out_byte = pdss_pkg::SLASH_BYTE;
               s2_item_in.out_last = 1'b1;
            end else begin
               s2_ram_in           = 1'b1;
               rdptr_in            = rd_next;
               s2_item_in.out_last = (rd_next >= committed_ff);
            end
            if (s2_item_in.out_last) begin
               committed_in = '0;
               seglen_in    = '0;
               alldots_in   = 1'b1;
               depth_in     = '0;
               rdptr_in     = '0;
               finished_in  = 1'b0;
            end
         end
         s2_item_in.overflow = overflow_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         committed_ff <= '0;
         seglen_ff    <= '0;
         alldots_ff   <= 1'b1;
         depth_ff     <= '0;
         rdptr_ff     <= '0;
         finished_ff  <= 1'b0;
         overflow_ff  <= 1'b0;
         pend_ff      <= 1'b0;
         s2_valid_ff  <= 1'b0;
      end else begin
         committed_ff <= committed_in;
         seglen_ff    <= seglen_in;
         alldots_ff   <= alldots_in;
         depth_ff     <= depth_in;
         rdptr_ff     <= rdptr_in;
         finished_ff  <= finished_in;
         overflow_ff  <= overflow_in;
         pend_ff      <= pend_in;
         s2_valid_ff  <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      top_ff       <= top_in;
      pend_addr_ff <= pend_addr_in;
      s2_ram_ff    <= s2_ram_in;
      s2_item_ff   <= s2_item_in;
   end

   always_comb begin
      rsp_item = s2_item_ff;
      if (s2_ram_ff) begin
         rsp_item.out_byte = buf_rdata;
      end
   end
   assign rsp_push = s2_valid_ff;

   pdss_ram #(
      .WIDTH (8),
      .DEPTH (BUF_DEPTH)
   ) u_path_buffer (
      .clock   (clock),
      .wr_en   (buf_we),
      .wr_addr (buf_waddr),
      .wr_data (buf_wdata),
      .rd_addr (buf_raddr),
      .rd_data (buf_rdata)
   );

   pdss_ram #(
      .WIDTH (AW),
      .DEPTH (MAX_SEGMENTS)
   ) u_segment_starts (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (stk_waddr),
      .wr_data (committed_ff[AW-1:0]),
      .rd_addr (stk_raddr),
      .rd_data (stk_rdata)
   );

   a_pend_one_cycle: assert property (@(posedge clock) disable iff (reset)
      pend_ff |=> !pend_ff)
      else $error("slash write held for more than one cycle");

   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= DEP_W'(MAX_SEGMENTS))
      else $error("segment stack depth beyond capacity");

   a_rdptr_bound: assert property (@(posedge clock) disable iff (reset)
      rdptr_ff == '0 || rdptr_ff < committed_ff)
      else $error("read pointer past committed length");

endmodule

[hw/rtl/path_dot_segment_simplifier.sv]
// A transaction passes the input queue, the result stage and the result queue
// before its result is on rsp_data.
// Throughput: one transaction per cycle while the result queue has room; a stored
// end-of-path byte closing a kept segment holds the engine for the second buffer write.
// Reset: synchronous; clears queues, path state and the sticky overflow flag.
// Path and segment memories are not cleared; no clearing pass follows reset.
module path_dot_segment_simplifier #(
   parameter int BUF_DEPTH    = pdss_pkg::BUF_DEPTH_DEFAULT,
   parameter int MAX_SEGMENTS = pdss_pkg::MAX_SEGMENTS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   input  pdss_pkg::req_type req_data,
   output logic              req_full,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output pdss_pkg::rsp_type rsp_data
);

   // Front: classify each byte ('/' and '.') and queue it for the engine.
   pdss_pkg::token_type tok;
   logic                tok_empty;
   logic                tok_pop;

   // Back to result queue: one result per transaction, in order.
   logic                                       back_push;
   pdss_pkg::rsp_type                          back_item;
   logic [$clog2(pdss_pkg::QUEUE_DEPTH+1)-1:0] out_count;
   logic                                       out_full;

   pdss_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .tok_pop   (tok_pop),
      .tok       (tok),
      .tok_empty (tok_empty)
   );

   // Engine: drops empty and "." segments, pops on "..", appends the rest,
   // then streams the canonical path out on read transactions. It only takes
   // a transaction when the result queue has a free slot for it.
   pdss_back #(
      .BUF_DEPTH    (BUF_DEPTH),
      .MAX_SEGMENTS (MAX_SEGMENTS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .tok_empty (tok_empty),
      .tok       (tok),
      .tok_pop   (tok_pop),
      .out_count (out_count),
      .rsp_push  (back_push),
      .rsp_item  (back_item)
   );

   // Result queue: decouple the consumer from the engine.
   pdss_fifo #(
      .item_type (pdss_pkg::rsp_type),
      .DEPTH     (pdss_pkg::QUEUE_DEPTH)
   ) u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (back_push),
      .push_item (back_item),
      .full      (out_full),
      .pop       (rsp_pop),
      .pop_item  (rsp_data),
      .empty     (rsp_empty),
      .count     (out_count)
   );

   // The engine's credit check must never let a result hit a full queue.
   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      back_push |-> !out_full)
      else $error("result pushed into a full result queue");

endmodule

[bench/path_dot_segment_simplifier_test.sv]
module path_dot_segment_simplifier_test;

   localparam int PATH_BYTES = pdss_pkg::BUF_DEPTH_DEFAULT;
   localparam int SEG_SLOTS  = pdss_pkg::MAX_SEGMENTS_DEFAULT;
   localparam int ITEM_GOAL  = 1250;

   // one row of the directed table: the transaction and, where it is obvious,
   // the result typed in by hand
   typedef struct packed {
      pdss_pkg::req_type req;
      logic              has_rsp;
      pdss_pkg::rsp_type rsp;
   } stim_row_type;

   logic              clock;
   logic              reset;
   logic              req_push;
   pdss_pkg::req_type req_data;
   logic              req_full;
   logic              rsp_empty;
   logic              rsp_pop;
   pdss_pkg::rsp_type rsp_data;

   path_dot_segment_simplifier dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   // Predicted path state, mirrored from the block's behavior
   logic [7:0] canon_mem [PATH_BYTES];
   logic [8:0] seg_start_mem [SEG_SLOTS];
   logic [8:0] kept_len;
   logic [8:0] open_len;
   logic       open_all_dots;
   logic [7:0] seg_depth;
   logic [8:0] read_idx;
   logic       path_done;
   logic       overflow_seen;

   pdss_pkg::rsp_type canon_out_q [$];
   stim_row_type      stim_rows [$];
   int                items_sent;
   int                mismatch_count;
   bit                send_burst;
   bit                rsp_burst;

   // Clock: period of 2
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Hard stop in case the handshake hangs
   initial begin
      #2000000;
      $display("path_dot_segment_simplifier_test: FAIL");
      $finish;
   end

   function void clear_path();
      kept_len      = '0;
      open_len      = '0;
      open_all_dots = 1'b1;
      seg_depth     = '0;
      read_idx      = '0;
      path_done     = 1'b0;
   endfunction

   // Close the open segment: drop empty and "." segments, pop on "..",
   // otherwise commit "/" plus the stored bytes
   function void close_segment();
      if (open_len == 0) begin
      end else if (open_all_dots && open_len == 1) begin
      end else if (open_all_dots && open_len == 2) begin
         if (seg_depth > 0) begin
            seg_depth = seg_depth - 1'b1;
            kept_len  = seg_start_mem[seg_depth[6:0]];
         end
      end else if (seg_depth >= SEG_SLOTS) begin
         overflow_seen = 1'b1;
      end else begin
         canon_mem[kept_len[7:0]]      = pdss_pkg::SLASH_BYTE;
         seg_start_mem[seg_depth[6:0]] = kept_len;
         seg_depth                     = seg_depth + 1'b1;
         kept_len                      = kept_len + 9'd1 + open_len;
      end
      open_len      = '0;
      open_all_dots = 1'b1;
   endfunction

   // Advance the predicted state by one transaction and return its result
   function pdss_pkg::rsp_type simplify_step(pdss_pkg::req_type r);
      pdss_pkg::rsp_type o;
      int                pos;
      int                p;
      o = '0;
      if (r.mode == pdss_pkg::MODE_PUSH) begin
         if (!path_done) begin
            if (r.data_byte == pdss_pkg::SLASH_BYTE) begin
               close_segment();
            end else begin
               pos = int'(kept_len) + 1 + int'(open_len);
               if (pos < PATH_BYTES) begin
                  canon_mem[8'(pos)] = r.data_byte;
                  open_len           = open_len + 1'b1;
                  if (r.data_byte != pdss_pkg::DOT_BYTE)
                     open_all_dots = 1'b0;
               end else begin
                  // byte past the buffer: drop it, flag it, keep the segment
                  overflow_seen = 1'b1;
                  open_all_dots = 1'b0;
               end
            end
            if (r.end_of_path) begin
               close_segment();
               path_done = 1'b1;
               read_idx  = '0;
            end
         end
      end else if (path_done) begin
         o.out_valid = 1'b1;
         if (kept_len == 0) begin
            // nothing kept: the path reads as a lone "/"
            o.out_byte = pdss_pkg::SLASH_BYTE;
            o.out_last = 1'b1;
         end else begin
            p = (read_idx >= PATH_BYTES) ? PATH_BYTES - 1 : int'(read_idx);
            o.out_byte = canon_mem[8'(p)];
            read_idx   = read_idx + 1'b1;
            if (read_idx >= kept_len)
               o.out_last = 1'b1;
         end
         if (o.out_last)
            clear_path();
      end
      o.overflow = overflow_seen;
      return o;
   endfunction

   // Compare one popped transaction with the oldest prediction
   function void check_result(pdss_pkg::rsp_type got);
      pdss_pkg::rsp_type want;
      if (canon_out_q.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("unexpected result: byte %h valid %b last %b ovf %b",
                     got.out_byte, got.out_valid, got.out_last, got.overflow);
      end else begin
         want = canon_out_q.pop_front();
         if (got.out_byte !== want.out_byte || got.out_valid !== want.out_valid ||
             got.out_last !== want.out_last || got.overflow !== want.overflow) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("mismatch: want byte %h valid %b last %b ovf %b, got %h %b %b %b",
                        want.out_byte, want.out_valid, want.out_last, want.overflow,
                        got.out_byte, got.out_valid, got.out_last, got.overflow);
         end
      end
   endfunction

   function stim_row_type row(logic m, logic [7:0] b, logic e,
                              logic has, logic [7:0] ob, logic ov, logic ol);
      stim_row_type t;
      t.req.mode        = m;
      t.req.data_byte   = b;
      t.req.end_of_path = e;
      t.has_rsp         = has;
      t.rsp.out_byte    = ob;
      t.rsp.out_valid   = ov;
      t.rsp.out_last    = ol;
      t.rsp.overflow    = 1'b0;
      return t;
   endfunction

   // Offer one transaction after a random gap, hold it until accepted, then
   // record the expected result (a typed one where the table gives it)
   task automatic send_item(input pdss_pkg::req_type r, input bit typed,
                            input pdss_pkg::rsp_type typed_rsp);
      int                gap;
      bit                ignored;
      pdss_pkg::rsp_type predicted;
      gap = send_burst ? 0 : $urandom_range(0, 15);
      @(negedge clock);
      if (gap > 0) begin
         req_push = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_push = 1'b1;
      req_data = r;
      @(posedge clock);
      while (req_full) @(posedge clock);
      ignored   = (r.mode == pdss_pkg::MODE_PUSH) && path_done;
      predicted = simplify_step(r);
      canon_out_q.insert(canon_out_q.size(), typed ? typed_rsp : predicted);
      if (!ignored)
         items_sent++;
   endtask

   task automatic send_req(input logic m, input logic [7:0] b, input logic e);
      pdss_pkg::req_type r;
      r.mode        = m;
      r.data_byte   = b;
      r.end_of_path = e;
      send_item(r, 1'b0, '0);
   endtask

   function logic [7:0] name_char(bit dotty);
      logic [7:0] c;
      if (dotty && $urandom_range(0, 3) == 0)
         return pdss_pkg::DOT_BYTE;
      c = 8'($urandom_range(0, 255));
      while (c == pdss_pkg::SLASH_BYTE) c = 8'($urandom_range(0, 255));
      return c;
   endfunction

   // One path: optional noise, a mostly well-formed path, then its readout
   task automatic run_path(input int idx);
      logic [7:0] path_q [$];
      bit         is_long_path;
      bit         broken;
      int         nseg;
      int         kind;
      int         len;
      int         cap;
      send_burst = ($urandom_range(0, 3) == 0);

      // noise: random transactions of either mode
      if ($urandom_range(0, 7) == 0)
         repeat ($urandom_range(1, 4))
            send_req(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                     $urandom_range(0, 5) == 0);

      if (!path_done) begin
         is_long_path = (idx == 4) || ($urandom_range(0, 59) == 0);
         // drain everything before a long path, and once early on
         if (is_long_path || idx == 2) begin
            @(negedge clock);
            req_push = 1'b0;
            while (canon_out_q.size() != 0) @(posedge clock);
         end

         cap  = is_long_path ? 300 : 1000;
         nseg = is_long_path ? 1000 : $urandom_range(0, 8);
         if ($urandom_range(0, 3) != 0)
            path_q.insert(path_q.size(), pdss_pkg::SLASH_BYTE);
         for (int s = 0; s < nseg && path_q.size() < cap; s++) begin
            if (s > 0) begin
               path_q.insert(path_q.size(), pdss_pkg::SLASH_BYTE);
               if ($urandom_range(0, 5) == 0)
                  path_q.insert(path_q.size(), pdss_pkg::SLASH_BYTE);
            end
            kind = $urandom_range(0, 9);
            case (kind)
               0: begin
               end
               1: path_q.insert(path_q.size(), pdss_pkg::DOT_BYTE);
               2, 3: begin
                  path_q.insert(path_q.size(), pdss_pkg::DOT_BYTE);
                  path_q.insert(path_q.size(), pdss_pkg::DOT_BYTE);
               end
               4: begin
                  len = $urandom_range(1, is_long_path ? 24 : 4);
                  repeat (len) path_q.insert(path_q.size(), pdss_pkg::DOT_BYTE);
               end
               default: begin
                  len = $urandom_range(1, is_long_path ? 24 : 6);
                  repeat (len) path_q.insert(path_q.size(), name_char(1'b1));
               end
            endcase
         end
         if ($urandom_range(0, 3) == 0)
            path_q.insert(path_q.size(), pdss_pkg::SLASH_BYTE);
         if (path_q.size() == 0)
            path_q.insert(path_q.size(), pdss_pkg::SLASH_BYTE);

         // a broken path leaves out its end marker and runs into the next one
         broken = ($urandom_range(0, 11) == 0);
         foreach (path_q[i])
            send_req(pdss_pkg::MODE_PUSH, path_q[i], (i == path_q.size() - 1) && !broken);
      end

      // read out, with the odd stray push mixed in
      while (path_done) begin
         if ($urandom_range(0, 11) == 0)
            send_req(pdss_pkg::MODE_PUSH, 8'($urandom_range(0, 255)),
                     1'($urandom_range(0, 1)));
         else
            send_req(pdss_pkg::MODE_READ, 8'($urandom_range(0, 255)),
                     1'($urandom_range(0, 1)));
      end
   endtask

   // Result side: random stall per transaction, bursts with no stall, and one
   // long hold-off so the input queue fills and req_full asserts
   initial begin
      int stall;
      int seen;
      rsp_pop   = 1'b0;
      rsp_burst = 1'b0;
      seen      = 0;
      @(negedge clock);
      wait (!reset);
      forever begin
         if (seen % 50 == 0)
            rsp_burst = ($urandom_range(0, 2) == 0);
         stall = rsp_burst ? 0 : $urandom_range(0, 15);
         if (seen == 300)
            stall = 400;
         @(negedge clock);
         if (stall > 0) begin
            rsp_pop = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_pop = 1'b1;
         @(posedge clock);
         while (rsp_empty) @(posedge clock);
         check_result(rsp_data);
         seen++;
      end
   end

   // Stimulus: reset, directed table, random paths, drain, verdict
   initial begin
      int idx;
      reset          = 1'b1;
      req_push       = 1'b0;
      req_data       = '0;
      items_sent     = 0;
      mismatch_count = 0;
      send_burst     = 1'b0;
      idx            = 0;
      clear_path();
      overflow_seen  = 1'b0;

      stim_rows = '{
         // read before any path is finished: the result comes back with out_valid clear
         row(pdss_pkg::MODE_READ, 8'hFF, 1'b0, 1'b1, 8'h00, 1'b0, 1'b0),
         // lone "/" closes an empty path
         row(pdss_pkg::MODE_PUSH, pdss_pkg::SLASH_BYTE, 1'b1, 1'b1, 8'h00, 1'b0, 1'b0),
         // push while the readout is pending is ignored
         row(pdss_pkg::MODE_PUSH, 8'h7A, 1'b0, 1'b1, 8'h00, 1'b0, 1'b0),
         // empty result reads as "/"
         row(pdss_pkg::MODE_READ, 8'h00, 1'b1, 1'b1, pdss_pkg::SLASH_BYTE, 1'b1, 1'b1),
         // "/./.../<00 FF>/../../.." : dot, three dots kept, pops, ".." at root
         row(pdss_pkg::MODE_PUSH, pdss_pkg::SLASH_BYTE, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0),
         row(pdss_pkg::MODE_PUSH, pdss_pkg::DOT_BYTE,   1'b0, 1'b0, 8'h00, 1'b0, 1'b0),
         row(pdss_pkg::MODE_PUSH, pdss_pkg::SLASH_BYTE, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0),
         row(pdss_pkg::MODE_PUSH, pdss_pkg::DOT_BYTE,   1'b0, 1'b0, 8'h00, 1'b0, 1'b0),
         row(pdss_pkg::MODE_PUSH, pdss_pkg::DOT_BYTE,   1'b0, 1'b0, 8'h00, 1'b0, 1'b0),
         row(pdss_pkg::MODE_PUSH, pdss_pkg::DOT_BYTE,   1'b0, 1'b0, 8'h00, 1'b0, 1'b0),
         row(pdss_pkg::MODE_PUSH, pdss_pkg::SLASH_BYTE, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0),
         row(pdss_pkg::MODE_PUSH, 8'h00,                1'b0, 1'b0, 8'h00, 1'b0, 1'b0),
         row(pdss_pkg::MODE_PUSH, 8'hFF,                1'b0, 1'b0, 8'h00, 1'b0, 1'b0),
         row(pdss_pkg::MODE_PUSH, pdss_pkg::SLASH_BYTE, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0),
         row(pdss_pkg::MODE_PUSH, pdss_pkg::DOT_BYTE,   1'b0, 1'b0, 8'h00, 1'b0, 1'b0),
         row(pdss_pkg::MODE_PUSH, pdss_pkg::DOT_BYTE,   1'b0, 1'b0, 8'h00, 1'b0, 1'b0),
         row(pdss_pkg::MODE_PUSH, pdss_pkg::SLASH_BYTE, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0),
         row(pdss_pkg::MODE_PUSH, pdss_pkg::DOT_BYTE,   1'b0, 1'b0, 8'h00, 1'b0, 1'b0),
         row(pdss_pkg::MODE_PUSH, pdss_pkg::DOT_BYTE,   1'b0, 1'b0, 8'h00, 1'b0, 1'b0),
         row(pdss_pkg::MODE_PUSH, pdss_pkg::SLASH_BYTE, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0),
         row(pdss_pkg::MODE_PUSH, pdss_pkg::DOT_BYTE,   1'b0, 1'b0, 8'h00, 1'b0, 1'b0),
         row(pdss_pkg::MODE_PUSH, pdss_pkg::DOT_BYTE,   1'b1, 1'b0, 8'h00, 1'b0, 1'b0),
         row(pdss_pkg::MODE_READ, 8'h55, 1'b0, 1'b1, pdss_pkg::SLASH_BYTE, 1'b1, 1'b1),
         // single-byte path "<80>" reads back as "/" then the byte
         row(pdss_pkg::MODE_PUSH, 8'h80, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0),
         row(pdss_pkg::MODE_READ, 8'hAA, 1'b0, 1'b1, pdss_pkg::SLASH_BYTE, 1'b1, 1'b0)
      };

      repeat (8) @(negedge clock);
      reset = 1'b0;

      foreach (stim_rows[i])
         send_item(stim_rows[i].req, stim_rows[i].has_rsp, stim_rows[i].rsp);

      // random paths; the first one also finishes the directed readout
      while (items_sent < ITEM_GOAL) begin
         run_path(idx);
         idx++;
      end

      @(negedge clock);
      req_push = 1'b0;

      // drain, then wait for any stray result to show up
      while (canon_out_q.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);

      if (mismatch_count == 0)
         $display("path_dot_segment_simplifier_test: PASS");
      else
         $display("path_dot_segment_simplifier_test: FAIL");
      $finish;
   end

endmodule

[sim.f]
hw/rtl/pdss_pkg.sv
hw/rtl/pdss_ram.sv
hw/rtl/pdss_fifo.sv
hw/rtl/pdss_front.sv
hw/rtl/pdss_back.sv
hw/rtl/path_dot_segment_simplifier.sv
bench/path_dot_segment_simplifier_test.sv
